@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; the deframer includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/dad_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dad_pkg;

  localparam int MAX_SEQ_LETTERS = 8;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_ZTEXT   = 3'd2;
  localparam logic [2:0] PH_COUNTED = 3'd3;
  localparam logic [2:0] PH_TAIL    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_NOLETTER  = 2'd2;
  localparam logic [1:0] ST_SHORT     = 2'd3;

  localparam logic [3:0] ADDR_COUNT   = 4'h0;
  localparam logic [3:0] ADDR_LETTERS = 4'h8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       article_last;
  } byte_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [7:0] entry_kind;
    logic [7:0] entry_number;
    logic       entry_done;
    logic [1:0] status;
    logic       article_done;
  } result_t;

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] letter_at(input logic [63:0] letters,
                                           input logic [3:0] pos);
    return letters[pos[2:0]*8 +: 8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/dictionary_article_deframer.sv @@
`timescale 1ns / 1ps
// A byte is held in the input register and moves into the result register once that
// register is free; a result that waits to be taken holds it in the input register.
// Throughput: one byte per cycle while the result register is not stalled; the input register
// and the result register each hold one item, so one byte is taken while a finished result waits.
// The parse step (one 32-bit shift/decrement and compare) sits between those registers.
// Reset (rst, synchronous): parser at entry start, counters zero, both registers empty,
// configuration registers zero.
`default_nettype none
`include "assert_macros.svh"
module dictionary_article_deframer
  import dad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire byte_t       byte_item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam logic [3:0] MAX_CNT = 4'(MAX_SEQ_LETTERS);

  logic [3:0]  sequence_count;
  logic [63:0] sequence_letters;

  logic        s1_valid;
  byte_t       s1_item;
  logic        advance;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [3:0]  sequence_position, sequence_position_next;
  logic [7:0]  current_kind, current_kind_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [1:0]  length_byte_count, length_byte_count_next;
  logic        skip_to_article_end, skip_to_article_end_next;
  logic [7:0]  entry_counter, entry_counter_next;
  result_t     res;

  logic [3:0]  cnt;
  logic [3:0]  pos_fin;
  logic [1:0]  end_st;
  logic [7:0]  b;
  logic        last;
  logic [7:0]  seq_letter;
  logic [31:0] shifted_len;
  logic [31:0] dec_len;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count   <= '0;
      sequence_letters <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        sequence_letters <= pwdata;
      end else begin
        sequence_count <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    prdata = (paddr == ADDR_LETTERS) ? sequence_letters :
             (paddr == ADDR_COUNT) ? {60'd0, sequence_count} : 64'd0;
  end

  // Handshake: the parse step fires when the input register moves into the result register.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign byte_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_item <= byte_item;
    end
  end

  // Parse step
  assign cnt         = (sequence_count > MAX_CNT) ? MAX_CNT : sequence_count;
  assign b           = s1_item.data_byte;
  assign last        = s1_item.article_last;
  assign seq_letter  = letter_at(sequence_letters, sequence_position);
  assign shifted_len = {bytes_remaining[23:0], b};
  assign dec_len     = (bytes_remaining != 32'd0) ? bytes_remaining - 32'd1 : 32'd0;
  assign pos_fin     = ((cnt != 4'd0) && (sequence_position < 4'd15)) ?
                       sequence_position + 4'd1 : sequence_position;

  // Status for an article that ends right after a completed entry.
  always_comb begin
    if ((cnt == 4'd0) || (pos_fin >= cnt)) begin
      end_st = ST_OK;
    end else if (pos_fin < cnt - 4'd1) begin
      end_st = ST_SHORT;
    end else if (is_lower(letter_at(sequence_letters, pos_fin)) ||
                 is_upper(letter_at(sequence_letters, pos_fin))) begin
      end_st = ST_OK;
    end else begin
      end_st = ST_NOLETTER;
    end
  end

  always_comb begin
    logic fin;
    fin                      = 1'b0;
    parse_phase_next         = parse_phase;
    sequence_position_next   = sequence_position;
    current_kind_next        = current_kind;
    bytes_remaining_next     = bytes_remaining;
    length_byte_count_next   = length_byte_count;
    skip_to_article_end_next = skip_to_article_end;
    entry_counter_next       = entry_counter;
    res.has_payload          = 1'b0;
    res.payload_byte         = 8'd0;
    res.entry_kind           = current_kind;
    res.entry_number         = entry_counter;
    res.entry_done           = 1'b0;
    res.status               = ST_OK;
    res.article_done         = last;

    if (skip_to_article_end) begin
      res.entry_kind   = 8'd0;
      res.entry_number = 8'd0;
    end else begin
      unique case (parse_phase)
        PH_START: begin
          if (cnt == 4'd0) begin
            res.entry_kind    = b;
            current_kind_next = b;
            if (is_lower(b)) begin
              parse_phase_next = PH_ZTEXT;
              if (last) res.status = ST_MALFORMED;
            end else if (is_upper(b)) begin
              parse_phase_next       = PH_LENGTH;
              length_byte_count_next = 2'd0;
              bytes_remaining_next   = 32'd0;
              if (last) res.status = ST_MALFORMED;
            end else begin
              res.status = ST_NOLETTER;
            end
          end else if (sequence_position >= cnt) begin
            res.entry_kind = 8'd0;
            res.status     = ST_MALFORMED;
          end else begin
            res.entry_kind    = seq_letter;
            current_kind_next = seq_letter;
            if (!is_lower(seq_letter) && !is_upper(seq_letter)) begin
              res.status = ST_NOLETTER;
            end else if (sequence_position == cnt - 4'd1) begin
              // The final letter's entry runs to the end of the article.
              res.has_payload  = 1'b1;
              res.payload_byte = b;
              parse_phase_next = PH_TAIL;
              if (last) begin
                res.entry_done = 1'b1;
                fin            = 1'b1;
              end
            end else if (is_lower(seq_letter)) begin
              if (b == 8'd0) begin
                res.entry_done = 1'b1;
                fin            = 1'b1;
                if (last) res.status = end_st;
              end else begin
                res.has_payload  = 1'b1;
                res.payload_byte = b;
                parse_phase_next = PH_ZTEXT;
                if (last) res.status = ST_MALFORMED;
              end
            end else begin
              bytes_remaining_next   = {24'd0, b};
              length_byte_count_next = 2'd1;
              parse_phase_next       = PH_LENGTH;
              if (last) res.status = ST_MALFORMED;
            end
          end
        end
        PH_LENGTH: begin
          bytes_remaining_next = shifted_len;
          if (length_byte_count == 2'd3) begin
            length_byte_count_next = 2'd0;
            if (shifted_len == 32'd0) begin
              res.entry_done = 1'b1;
              fin            = 1'b1;
              if (last) res.status = end_st;
            end else begin
              parse_phase_next = PH_COUNTED;
              if (last) res.status = ST_MALFORMED;
            end
          end else begin
            length_byte_count_next = length_byte_count + 2'd1;
            if (last) res.status = ST_MALFORMED;
          end
        end
        PH_ZTEXT: begin
          if (b == 8'd0) begin
            res.entry_done = 1'b1;
            fin            = 1'b1;
            if (last) res.status = end_st;
          end else begin
            res.has_payload  = 1'b1;
            res.payload_byte = b;
            if (last) res.status = ST_MALFORMED;
          end
        end
        PH_COUNTED: begin
          res.has_payload      = 1'b1;
          res.payload_byte     = b;
          bytes_remaining_next = dec_len;
          if (dec_len == 32'd0) begin
            res.entry_done = 1'b1;
            fin            = 1'b1;
            if (last) res.status = end_st;
          end else if (last) begin
            res.status = ST_MALFORMED;
          end
        end
        PH_TAIL: begin
          res.has_payload  = 1'b1;
          res.payload_byte = b;
          if (last) begin
            res.entry_done = 1'b1;
            fin            = 1'b1;
          end
        end
        default: begin
          parse_phase_next = PH_START;
          res.status       = ST_MALFORMED;
        end
      endcase

      if (fin) begin
        if (entry_counter != 8'hFF) entry_counter_next = entry_counter + 8'd1;
        sequence_position_next = pos_fin;
        parse_phase_next       = PH_START;
      end
      if (res.status != ST_OK) skip_to_article_end_next = 1'b1;
    end

    // Every article boundary returns the parser to its reset state.
    if (last) begin
      parse_phase_next         = PH_START;
      sequence_position_next   = 4'd0;
      current_kind_next        = 8'd0;
      bytes_remaining_next     = 32'd0;
      length_byte_count_next   = 2'd0;
      skip_to_article_end_next = 1'b0;
      entry_counter_next       = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase         <= PH_START;
      sequence_position   <= '0;
      current_kind        <= '0;
      bytes_remaining     <= '0;
      length_byte_count   <= '0;
      skip_to_article_end <= 1'b0;
      entry_counter       <= '0;
    end else if (advance) begin
      parse_phase         <= parse_phase_next;
      sequence_position   <= sequence_position_next;
      current_kind        <= current_kind_next;
      bytes_remaining     <= bytes_remaining_next;
      length_byte_count   <= length_byte_count_next;
      skip_to_article_end <= skip_to_article_end_next;
      entry_counter       <= entry_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item <= res;
    end
  end

  // Errors only arise at an entry start or on the last byte, so skipping implies entry start.
  `ASSERT_IMPLIES(a_skip_at_start, clk, rst, skip_to_article_end, parse_phase == PH_START)
  `ASSERT_IMPLIES(a_lencount_phase, clk, rst, length_byte_count != 2'd0,
                  parse_phase == PH_LENGTH)
  `ASSERT_NEXT(a_article_clear, clk, rst, advance && s1_item.article_last,
               entry_counter == 8'd0 && !skip_to_article_end && parse_phase == PH_START)
  `ASSERT_NEXT(a_skip_result, clk, rst, advance && skip_to_article_end,
               result_item.entry_kind == 8'd0 && !result_item.has_payload)

endmodule
`default_nettype wire

@@ verif/tb_dictionary_article_deframer.sv @@
`timescale 1ns / 1ps
module tb_dictionary_article_deframer;
  import dad_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1750;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRINT_LIMIT  = 50;

  typedef enum {ROW_BYTE, ROW_COUNT, ROW_LETTERS} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [63:0] value;
    logic        last;
    logic        typed;
    result_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  byte_t       byte_item;
  logic        result_valid;
  logic        result_ready;
  result_t     result_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  // Configuration as last written, and the parser state it drives.
  logic [3:0]  cfg_count;
  logic [63:0] cfg_letters;
  logic [2:0]  pr_phase;
  logic [3:0]  pr_pos;
  logic [7:0]  pr_kind;
  logic [31:0] pr_remaining;
  logic [1:0]  pr_len_bytes;
  logic        pr_skip;
  logic [7:0]  pr_entries;

  result_t  expected_results[$];
  byte_t    article_q[$];
  dir_row_t directed_rows[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       items_sent = 0;
  bit       calm = 1'b0;
  bit       hold_request = 1'b0;

  dictionary_article_deframer DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit lower_letter(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic bit upper_letter(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [3:0] active_letters();
    return (cfg_count > 4'd8) ? 4'd8 : cfg_count;
  endfunction

  function automatic logic [7:0] letter_for(input logic [3:0] pos);
    return cfg_letters[pos[2:0]*8 +: 8];
  endfunction

  function automatic logic [7:0] random_letter();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(10, 40));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic result_t outcome(input logic has, input logic [7:0] pay,
                                      input logic [7:0] kind, input logic [7:0] num,
                                      input logic done, input logic [1:0] st,
                                      input logic ad);
    return {has, pay, kind, num, done, st, ad};
  endfunction

  task automatic clear_article_state();
    pr_phase = PH_START;
    pr_pos = '0;
    pr_kind = '0;
    pr_remaining = '0;
    pr_len_bytes = '0;
    pr_skip = 1'b0;
    pr_entries = '0;
  endtask

  task automatic close_entry();
    if (pr_entries != 8'd255) pr_entries++;
    if (active_letters() != 4'd0 && pr_pos != 4'd15) pr_pos++;
    pr_phase = PH_START;
  endtask

  // Status when the article ends right after a complete entry.
  function automatic logic [1:0] status_at_end();
    logic [3:0] cnt;
    cnt = active_letters();
    if (cnt == 4'd0 || pr_pos >= cnt) return ST_OK;
    if (pr_pos < cnt - 4'd1) return ST_SHORT;
    if (lower_letter(letter_for(pr_pos)) || upper_letter(letter_for(pr_pos))) return ST_OK;
    return ST_NOLETTER;
  endfunction

  task automatic deframe_byte(input byte_t it, output result_t r);
    logic [7:0] b;
    logic [7:0] letter;
    logic [3:0] cnt;
    logic [1:0] st;
    logic       last;
    b = it.data_byte;
    last = it.article_last;
    cnt = active_letters();
    letter = letter_for(pr_pos);
    st = ST_OK;
    r = '0;
    r.entry_kind = pr_kind;
    r.entry_number = pr_entries;
    r.article_done = last;
    if (pr_skip) begin
      r.entry_kind = '0;
      r.entry_number = '0;
    end else begin
      case (pr_phase)
        PH_START: begin
          if (cnt == 4'd0) begin
            r.entry_kind = b;
            pr_kind = b;
            if (lower_letter(b)) begin
              pr_phase = PH_ZTEXT;
              if (last) st = ST_MALFORMED;
            end else if (upper_letter(b)) begin
              pr_phase = PH_LENGTH;
              pr_len_bytes = '0;
              pr_remaining = '0;
              if (last) st = ST_MALFORMED;
            end else begin
              st = ST_NOLETTER;
            end
          end else if (pr_pos >= cnt) begin
            r.entry_kind = '0;
            st = ST_MALFORMED;
          end else begin
            r.entry_kind = letter;
            pr_kind = letter;
            if (!lower_letter(letter) && !upper_letter(letter)) begin
              st = ST_NOLETTER;
            end else if (pr_pos == cnt - 4'd1) begin
              // The final letter's entry takes everything up to the article end.
              r.has_payload = 1'b1;
              r.payload_byte = b;
              pr_phase = PH_TAIL;
              if (last) begin
                r.entry_done = 1'b1;
                close_entry();
              end
            end else if (lower_letter(letter)) begin
              if (b == 8'h00) begin
                r.entry_done = 1'b1;
                close_entry();
                if (last) st = status_at_end();
              end else begin
                r.has_payload = 1'b1;
                r.payload_byte = b;
                pr_phase = PH_ZTEXT;
                if (last) st = ST_MALFORMED;
              end
            end else begin
              pr_remaining = {24'd0, b};
              pr_len_bytes = 2'd1;
              pr_phase = PH_LENGTH;
              if (last) st = ST_MALFORMED;
            end
          end
        end
        PH_LENGTH: begin
          pr_remaining = {pr_remaining[23:0], b};
          if (pr_len_bytes == 2'd3) begin
            pr_len_bytes = '0;
            if (pr_remaining == 32'd0) begin
              r.entry_done = 1'b1;
              close_entry();
              if (last) st = status_at_end();
            end else begin
              pr_phase = PH_COUNTED;
              if (last) st = ST_MALFORMED;
            end
          end else begin
            pr_len_bytes++;
            if (last) st = ST_MALFORMED;
          end
        end
        PH_ZTEXT: begin
          if (b == 8'h00) begin
            r.entry_done = 1'b1;
            close_entry();
            if (last) st = status_at_end();
          end else begin
            r.has_payload = 1'b1;
            r.payload_byte = b;
            if (last) st = ST_MALFORMED;
          end
        end
        PH_COUNTED: begin
          r.has_payload = 1'b1;
          r.payload_byte = b;
          if (pr_remaining != 32'd0) pr_remaining--;
          if (pr_remaining == 32'd0) begin
            r.entry_done = 1'b1;
            close_entry();
            if (last) st = status_at_end();
          end else if (last) begin
            st = ST_MALFORMED;
          end
        end
        PH_TAIL: begin
          r.has_payload = 1'b1;
          r.payload_byte = b;
          if (last) begin
            r.entry_done = 1'b1;
            close_entry();
          end
        end
        default: begin
          pr_phase = PH_START;
          st = ST_MALFORMED;
        end
      endcase
      r.status = st;
      if (st != ST_OK) pr_skip = 1'b1;
    end
    if (last) clear_article_state();
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic send_byte(input byte_t it, input logic typed = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    int gap;
    byte_valid <= 1'b1;
    byte_item <= it;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    deframe_byte(it, predicted);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    byte_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_COUNT) cfg_count = data[3:0];
    else cfg_letters = data;
    @(posedge clk);
  endtask

  task automatic add_row(input row_op_t op, input logic [63:0] value,
                         input logic last = 1'b0, input logic typed = 1'b0,
                         input result_t want = '0);
    directed_rows.push_back('{op, value, last, typed, want});
  endtask

  task automatic add_byte(input logic [7:0] b);
    article_q.push_back({b, 1'b0});
  endtask

  task automatic add_entry(input logic [7:0] kind);
    logic [31:0] len;
    if (lower_letter(kind)) begin
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(1, 255)));
      add_byte(8'h00);
    end else if (upper_letter(kind)) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 120) : $urandom_range(0, 8);
      add_byte(len[31:24]);
      add_byte(len[23:16]);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      repeat (len) add_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed articles; the rest are noise, cut short, or end early.
  task automatic build_article();
    int style;
    int cnt;
    int stop;
    int cut;
    logic [7:0] kind;
    article_q.delete();
    style = $urandom_range(0, 9);
    cnt = active_letters();
    if (style == 0) begin
      repeat ($urandom_range(1, 16)) add_byte(8'($urandom_range(0, 255)));
    end else if (cnt == 0) begin
      repeat ($urandom_range(1, 4)) begin
        kind = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : random_letter();
        add_byte(kind);
        add_entry(kind);
      end
    end else begin
      stop = (style == 1) ? $urandom_range(0, cnt - 1) : cnt - 1;
      for (int i = 0; i < stop; i++) add_entry(cfg_letters[i*8 +: 8]);
      if (style != 1) repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end
    if (article_q.size() == 0) add_byte(8'($urandom_range(0, 255)));
    if (style == 2) begin
      cut = $urandom_range(0, article_q.size() - 1);
      while (article_q.size() > cut + 1) void'(article_q.pop_back());
    end
    article_q[article_q.size() - 1].article_last = 1'b1;
  endtask

  initial begin : result_pacing
    forever begin
      if (hold_request) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected", result_item, 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (result_item.has_payload !== want.has_payload)
          report_mismatch("has_payload", result_item.has_payload, want.has_payload);
        if (result_item.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", result_item.payload_byte, want.payload_byte);
        if (result_item.entry_kind !== want.entry_kind)
          report_mismatch("entry_kind", result_item.entry_kind, want.entry_kind);
        if (result_item.entry_number !== want.entry_number)
          report_mismatch("entry_number", result_item.entry_number, want.entry_number);
        if (result_item.entry_done !== want.entry_done)
          report_mismatch("entry_done", result_item.entry_done, want.entry_done);
        if (result_item.status !== want.status)
          report_mismatch("status", result_item.status, want.status);
        if (result_item.article_done !== want.article_done)
          report_mismatch("article_done", result_item.article_done, want.article_done);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    dir_row_t    row;
    int          phase;
    int          random_start;
    logic [3:0]  count;
    logic [63:0] letters;
    rst <= 1'b1;
    byte_valid <= 1'b0;
    byte_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_count = '0;
    cfg_letters = '0;
    clear_article_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Inline mode after reset: a lowercase entry, then a counted uppercase one.
    add_row(ROW_BYTE, 64'h61, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'h61, 8'd0, 1'b0, ST_OK, 1'b0));
    add_row(ROW_BYTE, 64'hFF, 1'b0, 1'b1,
            outcome(1'b1, 8'hFF, 8'h61, 8'd0, 1'b0, ST_OK, 1'b0));
    add_row(ROW_BYTE, 64'h00, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'h61, 8'd0, 1'b1, ST_OK, 1'b0));
    add_row(ROW_BYTE, 64'h5A, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'h5A, 8'd1, 1'b0, ST_OK, 1'b0));
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h01);
    add_row(ROW_BYTE, 64'h80);
    // A type byte that is no letter; the rest of the article is skipped.
    add_row(ROW_BYTE, 64'h40, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'h40, 8'd2, 1'b0, ST_NOLETTER, 1'b0));
    add_row(ROW_BYTE, 64'h7B, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h00, 8'd0, 1'b0, ST_OK, 1'b1));
    // The article ends before a length field is complete.
    add_row(ROW_BYTE, 64'h41, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h41, 8'd0, 1'b0, ST_MALFORMED, 1'b1));
    add_row(ROW_BYTE, 64'h7B, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h7B, 8'd0, 1'b0, ST_NOLETTER, 1'b1));
    // Sequence mode with the letters a, B and x; B has zero length.
    add_row(ROW_LETTERS, 64'h0000_0000_0078_4261);
    add_row(ROW_COUNT, 64'd3);
    add_row(ROW_BYTE, 64'h68);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h70, 1'b1);
    // The article ends while letters other than the final one are pending.
    add_row(ROW_BYTE, 64'h00, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h61, 8'd0, 1'b1, ST_SHORT, 1'b1));
    // The count drops inside an article, so the sequence runs out.
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_COUNT, 64'd1);
    add_row(ROW_BYTE, 64'h55, 1'b0, 1'b1,
            outcome(1'b0, 8'h00, 8'h00, 8'd1, 1'b0, ST_MALFORMED, 1'b0));
    add_row(ROW_BYTE, 64'h00, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h00, 8'd0, 1'b0, ST_OK, 1'b1));
    // A count of zero inside an article switches to inline type bytes.
    add_row(ROW_COUNT, 64'd3);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_COUNT, 64'd0);
    add_row(ROW_BYTE, 64'h62);
    add_row(ROW_BYTE, 64'h00, 1'b1);
    // The final letter is not a letter, both as a pending entry and when reached.
    add_row(ROW_LETTERS, 64'h3161);
    add_row(ROW_COUNT, 64'd2);
    add_row(ROW_BYTE, 64'h00, 1'b1, 1'b1,
            outcome(1'b0, 8'h00, 8'h61, 8'd0, 1'b1, ST_NOLETTER, 1'b1));
    add_row(ROW_BYTE, 64'h78);
    add_row(ROW_BYTE, 64'h00);
    add_row(ROW_BYTE, 64'h05, 1'b1);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.op == ROW_BYTE) begin
        send_byte({row.value[7:0], row.last}, row.typed, row.want);
      end else begin
        drain();
        write_reg((row.op == ROW_COUNT) ? ADDR_COUNT : ADDR_LETTERS, row.value);
      end
    end

    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      letters = '0;
      for (int i = 0; i < 8; i++)
        letters[i*8 +: 8] = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                          : random_letter();
      case ($urandom_range(0, 7))
        0, 1: count = 4'd0;
        2: count = 4'd8;
        3: count = 4'($urandom_range(9, 15));
        default: count = 4'($urandom_range(1, 8));
      endcase
      if (phase == 0) begin
        count = 4'd0;
        letters = '1;
      end else if (phase == 1) begin
        count = 4'd8;
      end else if (phase == 2) begin
        count = 4'd15;
      end else if (phase == 3) begin
        count = 4'd1;
        letters = '0;
      end
      write_reg(ADDR_COUNT, {60'd0, count});
      write_reg(ADDR_LETTERS, letters);
      if (phase == 0) begin
        // Enough empty entries in one article to saturate the entry number.
        article_q.delete();
        repeat (260) begin
          add_byte(8'h61);
          add_byte(8'h00);
        end
        article_q[article_q.size() - 1].article_last = 1'b1;
        foreach (article_q[i]) send_byte(article_q[i]);
      end
      // The receiver stops for a long stretch while items keep coming.
      if (phase == 4) hold_request = 1'b1;
      repeat ($urandom_range(3, 10)) begin
        build_article();
        foreach (article_q[i]) send_byte(article_q[i]);
        if ($urandom_range(0, 5) == 0) drain();
      end
      phase++;
    end

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dad_pkg.sv
rtl/dictionary_article_deframer.sv
verif/tb_dictionary_article_deframer.sv
